// ===== rtl/gcbl_pkg.sv =====
package gcbl_pkg;

	localparam int CFG_W = 7;

	typedef enum logic [1:0] {
		FN_PUT  = 2'd0,
		FN_ITER = 2'd1,
		FN_CLR  = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ERR_OK   = 2'd0,
		ERR_OOB  = 2'd1,
		ERR_FULL = 2'd2,
		ERR_RSVD = 2'd3
	} err_t;

	localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_POOL_LIMIT  = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [7:0]  pos_x;
		logic signed [7:0]  pos_y;
		logic [31:0]        item_tag;
	} req_word_t;

	typedef struct packed {
		logic [31:0] item_out;
		logic        found;
		logic        last;
		logic [1:0]  error;
	} rsp_word_t;

endpackage

// ===== rtl/grid_cell_bucket_list_core.sv =====
// grid cell bucket list: a grid of cells, each heading a linked list of tags in a pool
// request channel (req_valid/req_stall/req_word): one word per operation, taken only
// while the block is idle; req_stall is high while an operation is in progress
// operations: put a tag into a cell, iterate a cell, clear the whole grid
// response channel (rsp_valid/rsp_stall/rsp_word): put and clear give one word;
// iterate gives one word per stored tag, newest first, last marked, or one
// not-found word for an empty cell; bounds and pool-full errors give one word
// steps: after calc and dispatch, clear and errors answer; put and iterate go on through
// head wait and head check, where a put writes its tag and an empty cell answers; iterate
// then walks the chain tag by tag through the single pool read port, one link per read
// one operation at a time: the next request is taken once the last word of the previous one
// is loaded into the output register
// the response word sits in an output register; while rsp_stall is high it holds,
// and a step that loads a new word waits there until that register frees up
// reset: after arst_n releases, the head table is swept to empty, one cell per cycle,
// over all MAX_WIDTH*MAX_HEIGHT cells (4096 by default) with req_stall high;
// configuration writes are taken at any time, also during the sweep
// a clear takes effect at once: heads are checked against the pool contents
// config registers reset to width 64, height 64, pool limit 64
module grid_cell_bucket_list_core
	import gcbl_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int POOL_DEPTH = 64,
	parameter int ITEM_BITS  = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_word_t        req_word,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_word_t        rsp_word,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
	localparam int CAW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int PAW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int LW  = $clog2(POOL_DEPTH + 1);
	localparam logic [7:0]       MAX_W_L  = 8'(MAX_WIDTH);
	localparam logic [7:0]       MAX_H_L  = 8'(MAX_HEIGHT);
	localparam logic [CFG_W-1:0] POOL_L   = CFG_W'(POOL_DEPTH);
	localparam logic [CAW-1:0]   CELL_END = CAW'(CELL_COUNT - 1);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CALC,
		S_DISP,
		S_HWAIT,
		S_HCHK,
		S_WALK,
		S_WDATA
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] grid_w_q, grid_h_q, pool_lim_q;
	logic [CAW-1:0]   init_q;
	logic [1:0]       func_q;
	logic signed [7:0] x_q, y_q;
	logic [ITEM_BITS-1:0] tag_q;
	logic [CAW-1:0]   cell_q;
	logic             oob_q;
	logic [LW-1:0]    count_q;
	logic [LW-1:0]    link_q;
	logic             rsp_valid_q;
	rsp_word_t        rsp_word_q;

	logic [LW-1:0]        head_mem [CELL_COUNT];
	logic [ITEM_BITS-1:0] item_mem [POOL_DEPTH];
	logic [LW-1:0]        next_mem [POOL_DEPTH];
	logic [CAW-1:0]       cell_mem [POOL_DEPTH];

	logic [LW-1:0]        head_rd;
	logic [ITEM_BITS-1:0] item_rd;
	logic [LW-1:0]        next_rd;
	logic [CAW-1:0]       cell_rd;

	logic [7:0]       w_eff, h_eff;
	logic [CFG_W-1:0] lim_eff;
	logic [15:0]      cell_calc;
	logic             oob_calc;
	logic             full;
	logic             out_free;
	logic             rsp_load;
	logic             link_ok;
	logic [LW-1:0]    link_new;
	logic [LW-1:0]    ptr_sel;
	logic [LW-1:0]    ptr_dec;
	logic [PAW-1:0]   pool_ra;
	logic [PAW-1:0]   pool_wa;
	logic             pool_we;
	logic             head_we;
	logic [CAW-1:0]   head_wa;
	logic [LW-1:0]    head_wd;
	logic [LW-1:0]    count_inc;
	logic [63:0]      tag_ext;
	logic [63:0]      item_ext;

	assign w_eff   = ({1'b0, grid_w_q} > MAX_W_L) ? MAX_W_L : {1'b0, grid_w_q};
	assign h_eff   = ({1'b0, grid_h_q} > MAX_H_L) ? MAX_H_L : {1'b0, grid_h_q};
	assign lim_eff = (pool_lim_q > POOL_L) ? POOL_L : pool_lim_q;

	assign cell_calc = 16'(y_q[6:0]) * 16'(w_eff) + 16'(x_q[6:0]);
	assign oob_calc  = x_q[7] || y_q[7] || (8'(x_q) >= w_eff) || (8'(y_q) >= h_eff);
	assign full      = CFG_W'(count_q) >= lim_eff;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign count_inc = count_q + LW'(1);

	// a new word goes into the output register this cycle
	assign rsp_load = out_free && (
		(state_q == S_DISP && (func_q == FN_CLR ||
			((func_q == FN_PUT || func_q == FN_ITER) &&
			((func_q == FN_PUT && full) || oob_q)))) ||
		(state_q == S_HCHK && (func_q == FN_PUT || link_new == '0)) ||
		(state_q == S_WDATA));

	// a head counts only if its slot was filled since the last clear and holds a tag of this cell
	assign link_ok  = (head_rd != '0) && (head_rd <= count_q) && (cell_rd == cell_q);
	assign link_new = link_ok ? head_rd : '0;

	assign ptr_sel = (state_q == S_WALK || state_q == S_WDATA) ? link_q : head_rd;
	assign ptr_dec = ptr_sel - LW'(1);
	assign pool_ra = ptr_dec[PAW-1:0];
	assign pool_wa = count_q[PAW-1:0];

	assign pool_we = (state_q == S_HCHK) && (func_q == FN_PUT) && out_free;
	assign head_we = (state_q == S_INIT) || pool_we;
	assign head_wa = (state_q == S_INIT) ? init_q : cell_q;
	assign head_wd = (state_q == S_INIT) ? '0 : count_inc;

	assign tag_ext  = 64'(req_word.item_tag);
	assign item_ext = 64'(item_rd);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_wa] <= head_wd;
		end
		head_rd <= head_mem[cell_q];
	end

	always_ff @(posedge clk) begin
		if (pool_we) begin
			item_mem[pool_wa] <= tag_q;
			next_mem[pool_wa] <= link_new;
			cell_mem[pool_wa] <= cell_q;
		end
		item_rd <= item_mem[pool_ra];
		next_rd <= next_mem[pool_ra];
		cell_rd <= cell_mem[pool_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_q      <= '0;
			grid_w_q    <= CFG_W'(64);
			grid_h_q    <= CFG_W'(64);
			pool_lim_q  <= CFG_W'(64);
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GRID_WIDTH:  grid_w_q   <= cfg_data;
					CFG_GRID_HEIGHT: grid_h_q   <= cfg_data;
					CFG_POOL_LIMIT:  pool_lim_q <= cfg_data;
					default: ;
				endcase
			end
			if (rsp_valid_q && !rsp_stall && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_q <= init_q + CAW'(1);
					if (init_q == CELL_END) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						func_q  <= req_word.func;
						x_q     <= req_word.pos_x;
						y_q     <= req_word.pos_y;
						tag_q   <= tag_ext[ITEM_BITS-1:0];
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					cell_q  <= cell_calc[CAW-1:0];
					oob_q   <= oob_calc;
					state_q <= S_DISP;
				end
				S_DISP: begin
					case (func_q)
						FN_PUT, FN_ITER: begin
							if ((func_q == FN_PUT && full) || oob_q) begin
								if (out_free) begin
									rsp_valid_q         <= 1'b1;
									rsp_word_q.item_out <= '0;
									rsp_word_q.found    <= 1'b0;
									rsp_word_q.last     <= 1'b1;
									rsp_word_q.error    <= (func_q == FN_PUT && full) ?
										ERR_FULL : ERR_OOB;
									state_q             <= S_IDLE;
								end
							end else begin
								state_q <= S_HWAIT;
							end
						end
						FN_CLR: begin
							if (out_free) begin
								count_q             <= '0;
								rsp_valid_q         <= 1'b1;
								rsp_word_q.item_out <= '0;
								rsp_word_q.found    <= 1'b0;
								rsp_word_q.last     <= 1'b1;
								rsp_word_q.error    <= ERR_OK;
								state_q             <= S_IDLE;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_HWAIT: begin
					state_q <= S_HCHK;
				end
				S_HCHK: begin
					if (func_q == FN_PUT) begin
						if (out_free) begin
							count_q             <= count_inc;
							rsp_valid_q         <= 1'b1;
							rsp_word_q.item_out <= '0;
							rsp_word_q.found    <= 1'b0;
							rsp_word_q.last     <= 1'b1;
							rsp_word_q.error    <= ERR_OK;
							state_q             <= S_IDLE;
						end
					end else if (link_new == '0) begin
						if (out_free) begin
							rsp_valid_q         <= 1'b1;
							rsp_word_q.item_out <= '0;
							rsp_word_q.found    <= 1'b0;
							rsp_word_q.last     <= 1'b1;
							rsp_word_q.error    <= ERR_OK;
							state_q             <= S_IDLE;
						end
					end else begin
						link_q  <= link_new;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					state_q <= S_WDATA;
				end
				S_WDATA: begin
					if (out_free) begin
						rsp_valid_q         <= 1'b1;
						rsp_word_q.item_out <= item_ext[31:0];
						rsp_word_q.found    <= 1'b1;
						rsp_word_q.last     <= (next_rd == '0);
						rsp_word_q.error    <= ERR_OK;
						if (next_rd == '0) begin
							state_q <= S_IDLE;
						end else begin
							link_q  <= next_rd;
							state_q <= S_WALK;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_init_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INIT |-> req_stall)
		else $error("request taken during head sweep");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LW'(POOL_DEPTH))
		else $error("pool count above depth");

	a_link_older: assert property (@(posedge clk) disable iff (!arst_n)
		pool_we |-> link_new <= count_q)
		else $error("put links to a newer slot");

	a_walk_link: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> (link_q != '0) && (link_q <= count_q))
		else $error("walk on an invalid link");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.found |-> rsp_word.error == ERR_OK)
		else $error("found word carries an error");

endmodule
